[sv/bvlf_pkg.sv]
// Shared constants, types and state codes of the battery voltage lag filter.
`default_nettype none
package bvlf_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int ALPHA_BITS = 16;

	localparam int MV_W     = 16;
	localparam int TIME_W   = 32;
	localparam int TAU_W    = 24;
	localparam int EST_W    = MV_W + FRAC_BITS;
	localparam int CHG_W    = 14;
	localparam int CFG_IX_W = 2;
	localparam int CFG_D_W  = 24;

	// shared divider: remainder and divisor span tau + dt
	localparam int DIV_W      = TIME_W + 1;
	localparam int DIV_LOW_W  = ALPHA_BITS;
	localparam int DIV_STEP_W = $clog2(DIV_LOW_W + 1);

	// blend accumulator: estimate scaled by 2^ALPHA_BITS plus sign and headroom
	localparam int ACC_W = EST_W + ALPHA_BITS + 2;
	localparam int MCNT_W = $clog2(ALPHA_BITS);

	// charge numerator: window offset times the scale
	localparam int NUM_W = EST_W + CHG_W;

	localparam logic [TAU_W-1:0] TAU_RST       = TAU_W'(10000);
	localparam logic [MV_W-1:0]  MIN_VALID_RST = MV_W'(1000);
	localparam logic [MV_W-1:0]  EMPTY_RST     = MV_W'(24000);
	localparam logic [MV_W-1:0]  FULL_RST      = MV_W'(29000);

	localparam logic [CHG_W-1:0] CHARGE_SCALE  = CHG_W'(10000);
	localparam logic [MV_W-1:0]  MIN_WINDOW_MV = MV_W'(10);

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_TAU_MS       = 2'd0,
		CFG_MIN_VALID_MV = 2'd1,
		CFG_EMPTY_MV     = 2'd2,
		CFG_FULL_MV      = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DEN,
		ST_DIV_A,
		ST_MUL,
		ST_BLEND,
		ST_CLAMP,
		ST_SCALE,
		ST_CHG_GO,
		ST_DIV_C,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIV_STEP_W-1:0] steps;
	} div_ctl_t;

endpackage
`default_nettype wire

[sv/bvlf_if.sv]
// Request channels of the battery voltage lag filter: samples, results, config writes.
`default_nettype none
interface bvlf_meas_if import bvlf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MV_W-1:0]   sample_mv;
	logic [TIME_W-1:0] time_ms;
	logic              restart;

	modport source (output valid, output sample_mv, output time_ms, output restart,
		input ready);
	modport sink (input valid, input sample_mv, input time_ms, input restart,
		output ready);
endinterface

interface bvlf_result_if import bvlf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             has_value;
	logic [MV_W-1:0]  filtered_mv;
	logic [CHG_W-1:0] charge_centi_pct;

	modport source (output valid, output has_value, output filtered_mv,
		output charge_centi_pct, input ready);
	modport sink (input valid, input has_value, input filtered_mv,
		input charge_centi_pct, output ready);
endinterface

interface bvlf_cfg_if import bvlf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CFG_IX_W-1:0] index;
	logic [CFG_D_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[sv/bvlf_div.sv]
// Restoring divider, one quotient bit per cycle, shared by alpha and charge.
`default_nettype none
module bvlf_div import bvlf_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire div_ctl_t             ctl,
	input  wire logic [DIV_W-1:0]     rem0,
	input  wire logic [DIV_LOW_W-1:0] low,
	input  wire logic [DIV_W-1:0]     den,
	output      logic                 done,
	output      logic [DIV_LOW_W-1:0] quo
);

	logic [DIV_W-1:0]      rem_q;
	logic [DIV_LOW_W-1:0]  low_q;
	logic [DIV_W-1:0]      den_q;
	logic [DIV_LOW_W-1:0]  quo_q;
	logic [DIV_STEP_W-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W+1:0] diff;
	logic             take;

	// rem0 is below den, so the shifted remainder stays below twice the divisor
	always_comb begin
		trial = {rem_q, low_q[DIV_LOW_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		take  = ~diff[DIV_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ctl.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= rem0;
			low_q <= low;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			low_q <= {low_q[DIV_LOW_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_LOW_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

[sv/battery_voltage_lag_filter_core.sv]
// Battery voltage lag filter: first-order low-pass over timestamped mV samples.
// One sample in, one result out. A sample below min_valid_mv leaves the filter
// untouched; the first valid sample seeds it; a later one with an advancing
// timestamp is blended with alpha = dt*2^16/(tau_ms+dt) (tau_ms 0 passes the
// sample through). A charge level is worked out only when there is a value and
// the empty-to-full window is not narrow. The shared divider yields one quotient
// bit a cycle (a 16-bit quotient for alpha, 14 bits for the charge level), and
// the blend uses a bit-serial multiplier. The next sample is taken once the
// result is in the output register, which holds it until the sink takes it.
`default_nettype none
module battery_voltage_lag_filter_core import bvlf_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bvlf_meas_if.sink   meas,
	bvlf_result_if.source result,
	bvlf_cfg_if.sink    cfg
);

	state_t state_q, state_d;

	// configuration
	logic [TAU_W-1:0] tau_q;
	logic [MV_W-1:0]  min_q, empty_q, full_q;

	// filter state
	logic              seeded_q;
	logic [EST_W-1:0]  est_q;
	logic [TIME_W-1:0] last_q;

	// working registers
	logic [MV_W-1:0]          smp_q;
	logic [TIME_W-1:0]        time_q;
	logic [TIME_W-1:0]        dt_q;
	logic [ALPHA_BITS-1:0]    alpha_q;
	logic signed [ACC_W-1:0]  acc_q, dsh_q;
	logic [MCNT_W-1:0]        mcnt_q;
	logic [EST_W-1:0]         v_q;
	logic                     win_ok_q;
	logic [MV_W-1:0]          win_q;
	logic [NUM_W-1:0]         n_q;
	logic [CHG_W-1:0]         chg_q;

	// output register
	logic             out_v_q;
	logic             out_has_q;
	logic [MV_W-1:0]  out_mv_q;
	logic [CHG_W-1:0] out_chg_q;

	// divider hookup
	div_ctl_t             div_ctl;
	logic [DIV_W-1:0]     div_rem0, div_den;
	logic [DIV_LOW_W-1:0] div_low, div_quo;
	logic                 div_done;

	// combinational helpers
	logic                    accept, out_free;
	logic                    smp_ok, advance, tau_zero;
	logic [EST_W-1:0]        target, lo, hi;
	logic signed [EST_W:0]   diff;
	logic [MV_W:0]           win;
	logic [EST_W:0]          rnd;
	logic [EST_W-1:0]        offs;

	assign accept   = meas.valid && meas.ready;
	assign out_free = !out_v_q || result.ready;

	always_comb begin
		smp_ok   = smp_q >= min_q;
		advance  = time_q > last_q;
		tau_zero = tau_q == '0;
		target   = {smp_q, {FRAC_BITS{1'b0}}};
		lo       = {empty_q, {FRAC_BITS{1'b0}}};
		hi       = {full_q, {FRAC_BITS{1'b0}}};
		diff     = $signed({1'b0, target}) - $signed({1'b0, est_q});
		win      = {1'b0, full_q} - {1'b0, empty_q};
		rnd      = {1'b0, est_q} + (EST_W+1)'(1 << (FRAC_BITS - 1));
		offs     = v_q - lo;
	end

	bvlf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.rem0   (div_rem0),
		.low    (div_low),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		meas.ready    = 1'b0;
		div_ctl.start = 1'b0;
		div_ctl.steps = DIV_STEP_W'(ALPHA_BITS);
		div_rem0      = {1'b0, dt_q};
		div_low       = '0;
		div_den       = {{(DIV_W-TAU_W){1'b0}}, tau_q} + {1'b0, dt_q};
		case (state_q)
			ST_IDLE: begin
				meas.ready = 1'b1;
				if (meas.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (smp_ok && seeded_q && advance && !tau_zero) begin
					state_d = ST_DEN;
				end else begin
					state_d = ST_CLAMP;
				end
			end
			ST_DEN: begin
				div_ctl.start = 1'b1;
				state_d       = ST_DIV_A;
			end
			ST_DIV_A: begin
				if (div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mcnt_q == MCNT_W'(ALPHA_BITS - 1)) begin
					state_d = ST_BLEND;
				end
			end
			ST_BLEND: begin
				state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				if (seeded_q && win_ok_q) begin
					state_d = ST_CHG_GO;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CHG_GO: begin
				// quotient is at most the scale, so 14 bits come out of the top
				div_ctl.start = 1'b1;
				div_ctl.steps = DIV_STEP_W'(CHG_W);
				div_rem0      = {{(DIV_W-EST_W){1'b0}}, n_q[NUM_W-1:CHG_W]};
				div_low       = {n_q[CHG_W-1:0], {(DIV_LOW_W-CHG_W){1'b0}}};
				div_den       = {{(DIV_W-EST_W){1'b0}}, win_q, {FRAC_BITS{1'b0}}};
				state_d       = ST_DIV_C;
			end
			ST_DIV_C: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration writes and filter state
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q    <= TAU_RST;
			min_q    <= MIN_VALID_RST;
			empty_q  <= EMPTY_RST;
			full_q   <= FULL_RST;
			seeded_q <= 1'b0;
			est_q    <= '0;
			last_q   <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_TAU_MS:       tau_q   <= cfg.data[TAU_W-1:0];
					CFG_MIN_VALID_MV: min_q   <= cfg.data[MV_W-1:0];
					CFG_EMPTY_MV:     empty_q <= cfg.data[MV_W-1:0];
					CFG_FULL_MV:      full_q  <= cfg.data[MV_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && meas.restart) begin
						seeded_q <= 1'b0;
						est_q    <= '0;
						last_q   <= '0;
					end
				end
				ST_CHECK: begin
					if (smp_ok && (!seeded_q || (advance && tau_zero))) begin
						// seed, or pass-through when tau is zero
						seeded_q <= 1'b1;
						est_q    <= target;
						last_q   <= time_q;
					end
				end
				ST_BLEND: begin
					est_q  <= acc_q[ALPHA_BITS +: EST_W];
					last_q <= time_q;
				end
				default: ;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					smp_q  <= meas.sample_mv;
					time_q <= meas.time_ms;
				end
			end
			ST_CHECK: begin
				dt_q <= time_q - last_q;
			end
			ST_DIV_A: begin
				// est' = (est*2^16 + alpha*(target - est) + half) >> 16
				alpha_q <= div_quo[ALPHA_BITS-1:0];
				acc_q   <= $signed({{(ACC_W-EST_W-ALPHA_BITS){1'b0}}, est_q,
					{ALPHA_BITS{1'b0}}}) + $signed(ACC_W'(1 << (ALPHA_BITS - 1)));
				dsh_q   <= ACC_W'(diff);
				mcnt_q  <= '0;
			end
			ST_MUL: begin
				if (alpha_q[0]) begin
					acc_q <= acc_q + dsh_q;
				end
				dsh_q   <= dsh_q <<< 1;
				alpha_q <= alpha_q >> 1;
				mcnt_q  <= mcnt_q + 1'b1;
			end
			ST_CLAMP: begin
				if (est_q < lo) begin
					v_q <= lo;
				end else if (est_q > hi) begin
					v_q <= hi;
				end else begin
					v_q <= est_q;
				end
				win_ok_q <= !win[MV_W] && (win[MV_W-1:0] > MIN_WINDOW_MV);
				win_q    <= win[MV_W-1:0];
			end
			ST_SCALE: begin
				n_q   <= NUM_W'(offs) * NUM_W'(CHARGE_SCALE);
				chg_q <= '0;
			end
			ST_DIV_C: begin
				if (div_done) begin
					chg_q <= div_quo[CHG_W-1:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_has_q <= seeded_q;
			if (!seeded_q) begin
				out_mv_q  <= '0;
				out_chg_q <= '0;
			end else begin
				out_mv_q  <= rnd[EST_W] ? {MV_W{1'b1}} : rnd[FRAC_BITS +: MV_W];
				out_chg_q <= chg_q;
			end
		end
	end

	assign result.valid            = out_v_q;
	assign result.has_value        = out_has_q;
	assign result.filtered_mv      = out_mv_q;
	assign result.charge_centi_pct = out_chg_q;

endmodule
`default_nettype wire
